@@ rtl/core/hbls_pkg.sv @@
// hbls_pkg: shared types, constants and the microcode ROM of the bandwidth
// estimator / layer selector. No dependencies; imported by every module.
package hbls_pkg;

   localparam int DEF_WINDOW_DEPTH = 32;
   localparam int DEF_LAYER_LIMIT  = 16;

   // Field widths
   localparam int RATE_W     = 20;
   localparam int BYTES_W    = 24;
   localparam int MS_W       = 16;
   localparam int WIN_LEN_W  = 6;
   localparam int LAYER_W    = 4;
   localparam int BYTE_SHIFT = 3;                   // bytes -> bits
   localparam int PROD_W     = BYTES_W + BYTE_SHIFT;
   localparam int Q_SHIFT    = 40;                  // Q40 reciprocals
   localparam int RECIP_W    = Q_SHIFT + 1;

   localparam logic [RATE_W-1:0] RATE_MAX = {RATE_W{1'b1}};

   // Configuration port
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 20;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_BW  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_INIT_BW = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_WIN_LEN = 2'd2;

   localparam logic [RATE_W-1:0]    RESET_MAX_BW  = 20'd300000;
   localparam logic [RATE_W-1:0]    RESET_INIT_BW = 20'd12000;
   localparam logic [WIN_LEN_W-1:0] RESET_WIN_LEN = 6'd20;

   localparam logic OP_MEASURE   = 1'b0;
   localparam logic OP_OFFER     = 1'b1;
   localparam logic KIND_MEASURE = 1'b0;
   localparam logic KIND_SELECT  = 1'b1;

   typedef struct packed {
      logic                operation;
      logic [BYTES_W-1:0]  sent_bytes;
      logic [MS_W-1:0]     elapsed_ms;
      logic [RATE_W-1:0]   layer_rate;
      logic                last_layer;
   } req_type;

   typedef struct packed {
      logic                result_kind;
      logic [RATE_W-1:0]   measured_rate;
      logic [RATE_W-1:0]   estimate;
      logic [LAYER_W-1:0]  chosen_layer;
      logic [RATE_W-1:0]   chosen_rate;
   } rsp_type;

   // Microcode
   localparam int PC_W = 4;
   typedef logic [PC_W-1:0] pc_type;

   localparam pc_type PC_IDLE    = 4'd0;
   localparam pc_type PC_RESTART = 4'd1;
   localparam pc_type PC_MEASURE = 4'd4;
   localparam pc_type PC_OFFER   = 4'd13;

   typedef enum logic [3:0] {
      UOP_NOP,
      UOP_DIV_INIT,
      UOP_INIT_COMMIT,
      UOP_DIV_RATE,
      UOP_RATE_LATCH,
      UOP_DIV_RECIP,
      UOP_WINDOW_UPDATE,
      UOP_DIV_MEAN,
      UOP_MEAS_EMIT,
      UOP_OFFER
   } uop_type;

   // NEXT: pc+1; ALWAYS: target; DIV_WAIT: hold while divider busy;
   // EMIT: hold while the output register is blocked, then target;
   // DISPATCH: idle step, picks an entry point.
   typedef enum logic [2:0] {
      COND_NEXT,
      COND_ALWAYS,
      COND_DIV_WAIT,
      COND_EMIT,
      COND_DISPATCH
   } cond_type;

   typedef struct packed {
      uop_type  uop;
      cond_type cond;
      pc_type   target;
   } ucode_type;

   typedef struct packed {
      logic div_busy;
      logic emit_block;
      logic restart_pending;
      logic req_fire;
      logic req_op;
   } seq_status_type;

   function automatic ucode_type ucode_rom(input pc_type pc);
      ucode_type word;
      word = '{uop: UOP_NOP, cond: COND_ALWAYS, target: PC_IDLE};
      case (pc)
         4'd0:  word = '{uop: UOP_NOP,           cond: COND_DISPATCH, target: PC_IDLE};
         // window restart: reciprocal of the seed sample
         4'd1:  word = '{uop: UOP_DIV_INIT,      cond: COND_NEXT,     target: PC_IDLE};
         4'd2:  word = '{uop: UOP_NOP,           cond: COND_DIV_WAIT, target: PC_IDLE};
         4'd3:  word = '{uop: UOP_INIT_COMMIT,   cond: COND_ALWAYS,   target: PC_IDLE};
         // measurement: rate, reciprocal, running sum, mean
         4'd4:  word = '{uop: UOP_DIV_RATE,      cond: COND_NEXT,     target: PC_IDLE};
         4'd5:  word = '{uop: UOP_NOP,           cond: COND_DIV_WAIT, target: PC_IDLE};
         4'd6:  word = '{uop: UOP_RATE_LATCH,    cond: COND_NEXT,     target: PC_IDLE};
         4'd7:  word = '{uop: UOP_DIV_RECIP,     cond: COND_NEXT,     target: PC_IDLE};
         4'd8:  word = '{uop: UOP_NOP,           cond: COND_DIV_WAIT, target: PC_IDLE};
         4'd9:  word = '{uop: UOP_WINDOW_UPDATE, cond: COND_NEXT,     target: PC_IDLE};
         4'd10: word = '{uop: UOP_DIV_MEAN,      cond: COND_NEXT,     target: PC_IDLE};
         4'd11: word = '{uop: UOP_NOP,           cond: COND_DIV_WAIT, target: PC_IDLE};
         4'd12: word = '{uop: UOP_MEAS_EMIT,     cond: COND_EMIT,     target: PC_IDLE};
         // layer offer
         4'd13: word = '{uop: UOP_OFFER,         cond: COND_EMIT,     target: PC_IDLE};
         default: word = '{uop: UOP_NOP, cond: COND_ALWAYS, target: PC_IDLE};
      endcase
      return word;
   endfunction

endpackage

@@ rtl/core/hbls_divider.sv @@
// hbls_divider: shared restoring divider, one quotient bit per cycle.
// Numerator comes in left-aligned with its bit count. Uses hbls_pkg.
module hbls_divider #(
   parameter int DIV_W = 46
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   input  logic [DIV_W-1:0]             num,
   input  logic [$clog2(DIV_W+1)-1:0]   steps,
   input  logic [DIV_W-1:0]             den,
   output logic                         busy,
   output logic [DIV_W-1:0]             quo
);
   import hbls_pkg::*;

   localparam int STEP_W = $clog2(DIV_W + 1);

   logic              busy_ff, busy_in;
   logic [STEP_W-1:0] cnt_ff, cnt_in;
   logic [DIV_W-1:0]  rem_ff, rem_in;
   logic [DIV_W-1:0]  quo_ff, quo_in;
   logic [DIV_W-1:0]  den_ff, den_in;

   logic [DIV_W:0] shifted;
   logic [DIV_W:0] diff;
   logic           fits;

   assign shifted = {rem_ff, quo_ff[DIV_W-1]};
   assign diff    = shifted - {1'b0, den_ff};
   assign fits    = shifted >= {1'b0, den_ff};

   always_comb begin
      busy_in = busy_ff;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      den_in  = den_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = steps;
         rem_in  = '0;
         quo_in  = num;
         den_in  = den;
      end else if (busy_ff) begin
         // quotient bits shift in at the bottom as the numerator leaves the top
         rem_in = fits ? diff[DIV_W-1:0] : shifted[DIV_W-1:0];
         quo_in = {quo_ff[DIV_W-2:0], fits};
         cnt_in = cnt_ff - STEP_W'(1);
         if (cnt_ff == STEP_W'(1)) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      den_ff <= den_in;
   end

   assign busy = busy_ff;
   assign quo  = quo_ff;

endmodule

@@ rtl/core/hbls_sequencer.sv @@
// hbls_sequencer: step counter and microcode ROM lookup with conditional jumps.
// Uses hbls_pkg for the control word, status struct and ROM.
module hbls_sequencer (
   input  logic                     clock,
   input  logic                     reset,
   input  hbls_pkg::seq_status_type status,
   output hbls_pkg::ucode_type      ctrl
);
   import hbls_pkg::*;

   pc_type    pc_ff, pc_in;
   ucode_type word;

   assign word = ucode_rom(pc_ff);
   assign ctrl = word;

   always_comb begin
      pc_in = pc_ff;
      case (word.cond)
         COND_NEXT:     pc_in = pc_ff + pc_type'(1);
         COND_ALWAYS:   pc_in = word.target;
         COND_DIV_WAIT: pc_in = status.div_busy ? pc_ff : pc_ff + pc_type'(1);
         COND_EMIT:     pc_in = status.emit_block ? pc_ff : word.target;
         COND_DISPATCH: begin
            if (status.restart_pending) begin
               pc_in = PC_RESTART;
            end else if (status.req_fire) begin
               pc_in = (status.req_op == OP_OFFER) ? PC_OFFER : PC_MEASURE;
            end
         end
         default:       pc_in = PC_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff <= PC_IDLE;
      end else begin
         pc_ff <= pc_in;
      end
   end

endmodule

@@ rtl/core/hbls_datapath.sv @@
// hbls_datapath: config registers, reciprocal ring memory, running sum,
// layer selection and the output register. Driven by hbls_sequencer control
// words; uses hbls_divider through its ports and hbls_pkg.
module hbls_datapath #(
   parameter int WINDOW_DEPTH = hbls_pkg::DEF_WINDOW_DEPTH,
   parameter int LAYER_LIMIT  = hbls_pkg::DEF_LAYER_LIMIT,
   parameter int SUM_W        = hbls_pkg::RECIP_W + $clog2(hbls_pkg::DEF_WINDOW_DEPTH)
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  hbls_pkg::req_type                 req_data,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output hbls_pkg::rsp_type                 rsp_data,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [hbls_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [hbls_pkg::CSR_DATA_W-1:0]   csr_wdata,
   input  hbls_pkg::ucode_type               ctrl,
   output hbls_pkg::seq_status_type          status,
   output logic                              div_start,
   output logic [SUM_W-1:0]                  div_num,
   output logic [$clog2(SUM_W+1)-1:0]        div_steps,
   output logic [SUM_W-1:0]                  div_den,
   input  logic                              div_busy,
   input  logic [SUM_W-1:0]                  div_quo
);
   import hbls_pkg::*;

   localparam int STEP_W = $clog2(SUM_W + 1);
   localparam int IDX_W  = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
   localparam int CNT_W  = $clog2(WINDOW_DEPTH + 1);
   localparam int CMP_W  = (CNT_W > WIN_LEN_W) ? CNT_W : WIN_LEN_W;
   localparam int LI_W   = (LAYER_LIMIT > 1) ? $clog2(LAYER_LIMIT) : 1;

   localparam logic [CMP_W-1:0] DEPTH_CMP  = CMP_W'(WINDOW_DEPTH);
   localparam logic [CNT_W:0]   DEPTH_WRAP = (CNT_W+1)'(WINDOW_DEPTH);
   localparam logic [IDX_W-1:0] LAST_SLOT  = IDX_W'(WINDOW_DEPTH - 1);
   localparam logic [LI_W-1:0]  LAST_OFFER = LI_W'(LAYER_LIMIT - 1);
   localparam logic [SUM_W-1:0] RECIP_ONE  = {1'b1, {(SUM_W-1){1'b0}}};

   // registers
   logic [RATE_W-1:0]    max_bw_ff, max_bw_in;
   logic [RATE_W-1:0]    init_bw_ff, init_bw_in;
   logic [WIN_LEN_W-1:0] win_len_ff, win_len_in;
   logic                 pending_ff, pending_in;
   req_type              item_ff, item_in;
   logic [RATE_W-1:0]    rate_ff, rate_in;
   logic [IDX_W-1:0]     head_ff, head_in;
   logic [CNT_W-1:0]     count_ff, count_in;
   logic [CNT_W-1:0]     zcount_ff, zcount_in;
   logic [SUM_W-1:0]     sum_ff, sum_in;
   logic [RATE_W-1:0]    est_ff, est_in;
   logic [LI_W-1:0]      offer_idx_ff, offer_idx_in;
   logic [LI_W-1:0]      best_layer_ff, best_layer_in;
   logic [RATE_W-1:0]    best_rate_ff, best_rate_in;
   logic                 full_ff, full_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   rsp_type              rsp_ff, rsp_in;

   // reciprocal ring
   logic [RECIP_W-1:0]   ring_mem [WINDOW_DEPTH];
   logic [RECIP_W-1:0]   ring_rd_ff;
   logic                 mem_we, mem_re;
   logic [IDX_W-1:0]     mem_waddr;

   logic                 idle, csr_fire, req_fire, out_blocked, emit_block, step_go;
   logic [RATE_W-1:0]    rate_cap, est_calc;
   logic [RECIP_W-1:0]   recip_new;
   logic [CMP_W-1:0]     win_x, eff_x;
   logic                 evict;
   logic [CNT_W:0]       tail_sum, tail_wrap;
   logic [IDX_W-1:0]     tail_idx, head_inc;
   logic                 take;
   logic [LI_W-1:0]      best_layer_nx;
   logic [RATE_W-1:0]    best_rate_nx;

   // handshakes
   assign idle        = ctrl.cond == COND_DISPATCH;
   assign csr_ready   = idle;
   assign csr_fire    = csr_valid && idle;
   assign req_stall   = !(idle && !pending_ff && !csr_valid);
   assign req_fire    = req_valid && !req_stall;
   assign out_blocked = rsp_valid_ff && rsp_stall;
   assign emit_block  = out_blocked && ((ctrl.uop == UOP_MEAS_EMIT) ||
                                        (ctrl.uop == UOP_OFFER && item_ff.last_layer));
   assign step_go     = !emit_block;

   assign status = '{div_busy: div_busy, emit_block: emit_block,
                     restart_pending: pending_ff, req_fire: req_fire,
                     req_op: req_data.operation};

   // divider command
   always_comb begin
      div_start = ctrl.uop inside {UOP_DIV_INIT, UOP_DIV_RATE, UOP_DIV_RECIP, UOP_DIV_MEAN};
      div_num   = '0;
      div_steps = '0;
      div_den   = '0;
      case (ctrl.uop)
         UOP_DIV_INIT: begin
            div_num   = RECIP_ONE;
            div_steps = STEP_W'(RECIP_W);
            div_den   = SUM_W'(init_bw_ff);
         end
         UOP_DIV_RATE: begin
            // zero time divides to all ones, which the cap turns into max
            div_num   = {item_ff.sent_bytes, {BYTE_SHIFT{1'b0}}, {(SUM_W-PROD_W){1'b0}}};
            div_steps = STEP_W'(PROD_W);
            div_den   = SUM_W'(item_ff.elapsed_ms);
         end
         UOP_DIV_RECIP: begin
            div_num   = RECIP_ONE;
            div_steps = STEP_W'(RECIP_W);
            div_den   = SUM_W'(rate_ff);
         end
         UOP_DIV_MEAN: begin
            div_num   = SUM_W'(count_ff) << Q_SHIFT;
            div_steps = STEP_W'(SUM_W);
            div_den   = sum_ff;
         end
         default: begin
            div_num   = '0;
         end
      endcase
   end

   // quotient interpretation; a zero sample is stored as a zero reciprocal
   always_comb begin
      rate_cap  = (div_quo > SUM_W'(max_bw_ff)) ? max_bw_ff : div_quo[RATE_W-1:0];
      est_calc  = (zcount_ff != '0) ? '0 :
                  (div_quo > SUM_W'(RATE_MAX)) ? RATE_MAX : div_quo[RATE_W-1:0];
      if (ctrl.uop == UOP_INIT_COMMIT) begin
         recip_new = (init_bw_ff == '0) ? '0 : div_quo[RECIP_W-1:0];
      end else begin
         recip_new = (rate_ff == '0) ? '0 : div_quo[RECIP_W-1:0];
      end
   end

   // window bookkeeping
   always_comb begin
      win_x = CMP_W'(win_len_ff);
      if (win_x == '0) begin
         eff_x = CMP_W'(1);
      end else if (win_x > DEPTH_CMP) begin
         eff_x = DEPTH_CMP;
      end else begin
         eff_x = win_x;
      end
      evict     = CMP_W'(count_ff) >= eff_x;
      tail_sum  = (CNT_W+1)'(head_ff) + (CNT_W+1)'(count_ff);
      tail_wrap = (tail_sum >= DEPTH_WRAP) ? tail_sum - DEPTH_WRAP : tail_sum;
      tail_idx  = tail_wrap[IDX_W-1:0];
      head_inc  = (head_ff == LAST_SLOT) ? '0 : head_ff + IDX_W'(1);
   end

   // layer selection
   always_comb begin
      take          = !full_ff && ((offer_idx_ff == '0) || (item_ff.layer_rate <= est_ff));
      best_layer_nx = take ? offer_idx_ff : best_layer_ff;
      best_rate_nx  = take ? item_ff.layer_rate : best_rate_ff;
   end

   assign mem_we    = step_go && ((ctrl.uop == UOP_INIT_COMMIT) ||
                                  (ctrl.uop == UOP_WINDOW_UPDATE));
   assign mem_re    = ctrl.uop == UOP_RATE_LATCH;
   assign mem_waddr = (ctrl.uop == UOP_INIT_COMMIT) ? '0 : tail_idx;

   always_ff @(posedge clock) begin
      if (mem_we) begin
         ring_mem[mem_waddr] <= recip_new;
      end
      if (mem_re) begin
         ring_rd_ff <= ring_mem[head_ff];
      end
   end

   // next state
   always_comb begin
      max_bw_in     = max_bw_ff;
      init_bw_in    = init_bw_ff;
      win_len_in    = win_len_ff;
      pending_in    = pending_ff;
      item_in       = item_ff;
      rate_in       = rate_ff;
      head_in       = head_ff;
      count_in      = count_ff;
      zcount_in     = zcount_ff;
      sum_in        = sum_ff;
      est_in        = est_ff;
      offer_idx_in  = offer_idx_ff;
      best_layer_in = best_layer_ff;
      best_rate_in  = best_rate_ff;
      full_in       = full_ff;
      rsp_valid_in  = out_blocked;
      rsp_in        = rsp_ff;

      if (req_fire) begin
         item_in = req_data;
      end

      if (idle && pending_ff) begin
         pending_in = 1'b0;
      end
      if (csr_fire) begin
         case (csr_index)
            CSR_MAX_BW:  max_bw_in  = csr_wdata[RATE_W-1:0];
            CSR_INIT_BW: begin
               init_bw_in = csr_wdata[RATE_W-1:0];
               pending_in = 1'b1;
            end
            CSR_WIN_LEN: win_len_in = csr_wdata[WIN_LEN_W-1:0];
            default:     pending_in = pending_in;
         endcase
      end

      if (step_go) begin
         case (ctrl.uop)
            UOP_INIT_COMMIT: begin
               // seed sample alone: mean of one sample is the sample
               head_in   = '0;
               count_in  = CNT_W'(1);
               zcount_in = CNT_W'(init_bw_ff == '0);
               sum_in    = SUM_W'(recip_new);
               est_in    = init_bw_ff;
            end
            UOP_RATE_LATCH: begin
               rate_in = rate_cap;
            end
            UOP_WINDOW_UPDATE: begin
               sum_in    = sum_ff + SUM_W'(recip_new) -
                           (evict ? SUM_W'(ring_rd_ff) : '0);
               zcount_in = zcount_ff + CNT_W'(rate_ff == '0) -
                           CNT_W'(evict && (ring_rd_ff == '0));
               if (evict) begin
                  head_in = head_inc;
               end else begin
                  count_in = count_ff + CNT_W'(1);
               end
            end
            UOP_MEAS_EMIT: begin
               est_in       = est_calc;
               rsp_valid_in = 1'b1;
               rsp_in       = '{result_kind: KIND_MEASURE, measured_rate: rate_ff,
                                estimate: est_calc, chosen_layer: '0, chosen_rate: '0};
            end
            UOP_OFFER: begin
               if (item_ff.last_layer) begin
                  rsp_valid_in  = 1'b1;
                  rsp_in        = '{result_kind: KIND_SELECT, measured_rate: '0,
                                    estimate: est_ff,
                                    chosen_layer: LAYER_W'(best_layer_nx),
                                    chosen_rate: best_rate_nx};
                  offer_idx_in  = '0;
                  best_layer_in = '0;
                  best_rate_in  = '0;
                  full_in       = 1'b0;
               end else begin
                  best_layer_in = best_layer_nx;
                  best_rate_in  = best_rate_nx;
                  if (!full_ff) begin
                     if (offer_idx_ff == LAST_OFFER) begin
                        full_in = 1'b1;
                     end else begin
                        offer_idx_in = offer_idx_ff + LI_W'(1);
                     end
                  end
               end
            end
            default: begin
               rate_in = rate_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         max_bw_ff     <= RESET_MAX_BW;
         init_bw_ff    <= RESET_INIT_BW;
         win_len_ff    <= RESET_WIN_LEN;
         pending_ff    <= 1'b1;           // seed reciprocal computed after reset
         head_ff       <= '0;
         count_ff      <= CNT_W'(1);
         zcount_ff     <= '0;
         est_ff        <= RESET_INIT_BW;
         offer_idx_ff  <= '0;
         best_layer_ff <= '0;
         best_rate_ff  <= '0;
         full_ff       <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         max_bw_ff     <= max_bw_in;
         init_bw_ff    <= init_bw_in;
         win_len_ff    <= win_len_in;
         pending_ff    <= pending_in;
         head_ff       <= head_in;
         count_ff      <= count_in;
         zcount_ff     <= zcount_in;
         est_ff        <= est_in;
         offer_idx_ff  <= offer_idx_in;
         best_layer_ff <= best_layer_in;
         best_rate_ff  <= best_rate_in;
         full_ff       <= full_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      item_ff <= item_in;
      rate_ff <= rate_in;
      sum_ff  <= sum_in;
      rsp_ff  <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

@@ rtl/core/harmonic_bandwidth_layer_select_unit.sv @@
// harmonic_bandwidth_layer_select_unit: top level of the harmonic-mean bandwidth
// estimator with layer selection. Instantiates hbls_sequencer, hbls_datapath
// and hbls_divider; uses hbls_pkg.
//
//   channel  direction  handshake        payload
//   req_     in         valid / stall    hbls_pkg::req_type
//   rsp_     out        valid / stall    hbls_pkg::rsp_type
//   csr_     in         valid / ready    csr_index, csr_wdata
//
// A measurement makes three passes through the bit-serial divider: rate,
// Q40 reciprocal, mean. After reset and after each initial_bandwidth write
// a restart computes the seed reciprocal; req_stall stays high meanwhile.
// A finished result sits in the output register while the next transaction is
// taken; the sequencer only holds when a second result is due.
module harmonic_bandwidth_layer_select_unit #(
   parameter int WINDOW_DEPTH = hbls_pkg::DEF_WINDOW_DEPTH,
   parameter int LAYER_LIMIT  = hbls_pkg::DEF_LAYER_LIMIT
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  hbls_pkg::req_type                 req_data,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output hbls_pkg::rsp_type                 rsp_data,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [hbls_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [hbls_pkg::CSR_DATA_W-1:0]   csr_wdata
);
   import hbls_pkg::*;

   // running sum of up to WINDOW_DEPTH Q40 reciprocals
   localparam int SUM_W  = RECIP_W + $clog2(WINDOW_DEPTH);
   localparam int STEP_W = $clog2(SUM_W + 1);

   ucode_type         ctrl;
   seq_status_type    status;
   logic              div_start;
   logic [SUM_W-1:0]  div_num;
   logic [STEP_W-1:0] div_steps;
   logic [SUM_W-1:0]  div_den;
   logic              div_busy;
   logic [SUM_W-1:0]  div_quo;

   hbls_sequencer u_sequencer (
      .clock  (clock),
      .reset  (reset),
      .status (status),
      .ctrl   (ctrl)
   );

   hbls_datapath #(
      .WINDOW_DEPTH (WINDOW_DEPTH),
      .LAYER_LIMIT  (LAYER_LIMIT),
      .SUM_W        (SUM_W)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .ctrl      (ctrl),
      .status    (status),
      .div_start (div_start),
      .div_num   (div_num),
      .div_steps (div_steps),
      .div_den   (div_den),
      .div_busy  (div_busy),
      .div_quo   (div_quo)
   );

   hbls_divider #(
      .DIV_W (SUM_W)
   ) u_divider (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (div_num),
      .steps (div_steps),
      .den   (div_den),
      .busy  (div_busy),
      .quo   (div_quo)
   );

endmodule
